@@ sv/hcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types, constants and helpers of the Harris corner response unit.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned Window    = 5;
  localparam int unsigned HalfWin   = Window / 2;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = 10;
  localparam int unsigned WinIdxW   = $clog2(Window);
  localparam int unsigned AddrW     = 5;
  localparam int unsigned NumWeight = 6;

  localparam logic [RowW-1:0] RowLimit = RowW'(1023);
  localparam logic [10:0] WidthMin     = 11'd5;
  localparam logic [10:0] WidthMax     = 11'(MaxWidth);

  typedef enum logic [2:0] {
    RegImageWidth = 3'd0,
    RegKCoeff     = 3'd1,
    RegWCenter    = 3'd2,
    RegWAxisNear  = 3'd3,
    RegWAxisFar   = 3'd4,
    RegWDiagNear  = 3'd5,
    RegWKnight    = 3'd6,
    RegWCorner    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] image_width;
    logic [15:0] k_coeff;
    logic [NumWeight-1:0][15:0] weight;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic shift;
    logic mul;
    logic acc;
    logic fin1;
    logic fin2;
    logic fin3;
    logic fin4;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic want_result;
    logic idx_last;
    logic out_free;
  } status_t;

  // Weight register number for a window position (row, col both 0..4).
  function automatic logic [2:0] weight_sel(input logic [WinIdxW-1:0] r,
                                            input logic [WinIdxW-1:0] c);
    logic [WinIdxW-1:0] a;
    logic [WinIdxW-1:0] b;
    logic [WinIdxW-1:0] lo;
    logic [WinIdxW-1:0] hi;
    a  = (r >= WinIdxW'(HalfWin)) ? r - WinIdxW'(HalfWin) : WinIdxW'(HalfWin) - r;
    b  = (c >= WinIdxW'(HalfWin)) ? c - WinIdxW'(HalfWin) : WinIdxW'(HalfWin) - c;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi == '0) return 3'd0;
    if (lo == '0) return (hi == WinIdxW'(1)) ? 3'd1 : 3'd2;
    if (lo == WinIdxW'(1)) return (hi == WinIdxW'(1)) ? 3'd3 : 3'd4;
    return 3'd5;
  endfunction

endpackage

@@ sv/hcr_if.sv @@
// ----------------------------------------------------------------------------
// hcr_in_if / hcr_out_if
// Valid/ready channels for gradient pixels and corner responses.
// ----------------------------------------------------------------------------
interface hcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] grad_x;
  logic [7:0] grad_y;
  logic       frame_start;

  modport source (output valid, grad_x, grad_y, frame_start, input ready);
  modport sink   (input valid, grad_x, grad_y, frame_start, output ready);
endinterface

interface hcr_out_if;
  logic        valid;
  logic        ready;
  logic [60:0] response;
  logic [9:0]  center_row;
  logic [9:0]  center_col;
  logic [58:0] frame_max;

  modport source (output valid, response, center_row, center_col, frame_max,
                  input ready);
  modport sink   (input valid, response, center_row, center_col, frame_max,
                  output ready);
endinterface

@@ sv/hcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcr_ctrl
// Sequencer: line store clearing, window update, accumulation and finish.
// ----------------------------------------------------------------------------
module hcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hcr_pkg::status_t status_i,
  output hcr_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StShift, StMul, StAcc,
    StFin1, StFin2, StFin3, StFin4, StLoad
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (status_i.clr_last) state_d = StIdle;
      StIdle:  if (in_valid_i) state_d = StShift;
      StShift: state_d = status_i.want_result ? StMul : StIdle;
      StMul:   state_d = StAcc;
      StAcc:   state_d = status_i.idx_last ? StFin1 : StMul;
      StFin1:  state_d = StFin2;
      StFin2:  state_d = StFin3;
      StFin3:  state_d = StFin4;
      StFin4:  state_d = StLoad;
      StLoad:  if (status_i.out_free) state_d = StIdle;
      default: state_d = StClear;
    endcase
    ready_d = (state_d == StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o  = ready_q;
  assign cmd_o.clear = (state_q == StClear);
  assign cmd_o.start = ready_q && in_valid_i;
  assign cmd_o.shift = (state_q == StShift);
  assign cmd_o.mul   = (state_q == StMul);
  assign cmd_o.acc   = (state_q == StAcc);
  assign cmd_o.fin1  = (state_q == StFin1);
  assign cmd_o.fin2  = (state_q == StFin2);
  assign cmd_o.fin3  = (state_q == StFin3);
  assign cmd_o.fin4  = (state_q == StFin4);
  assign cmd_o.load  = (state_q == StLoad) && status_i.out_free;

endmodule

@@ sv/hcr_dpath.sv @@
// ----------------------------------------------------------------------------
// hcr_dpath
// Line store, 5x5 window, counters, weighted accumulator and response math.
// ----------------------------------------------------------------------------
module hcr_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcr_pkg::cfg_t     cfg_i,
  input  hcr_pkg::cmd_t     cmd_i,
  output hcr_pkg::status_t  status_o,
  input  logic [7:0]        grad_x_i,
  input  logic [7:0]        grad_y_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [60:0]       response_o,
  output logic [9:0]        center_row_o,
  output logic [9:0]        center_col_o,
  output logic [58:0]       frame_max_o
);

  localparam int unsigned CW = hcr_pkg::ColW;
  localparam int unsigned RW = hcr_pkg::RowW;
  localparam int unsigned IW = hcr_pkg::WinIdxW;

  // Each word holds the four stored rows of one column, newest in the low bits.
  logic [63:0] mem [hcr_pkg::MaxWidth];
  logic [63:0] rd_q;
  logic [CW-1:0] clr_q;

  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;
  logic [CW-1:0] cur_col_q;
  logic [RW-1:0] cur_row_q;
  logic [15:0]   pix_q;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [10:0]   eff_w;
  logic [10:0]   col_inc;

  logic [15:0] win_q [hcr_pkg::Window][hcr_pkg::Window];
  logic [15:0] colv [hcr_pkg::Window];
  logic [IW-1:0] r_q, c_q;
  logic [15:0] sel_pix;
  logic [15:0] wt;
  logic [11:0] wx_q, wy_q;
  logic [23:0] wx_full, wy_full;
  logic [28:0] xx_q, yy_q, xy_q;

  logic [29:0] tr_q;
  logic [57:0] xxyy_q, xyxy_q;
  logic [59:0] t2_q;
  logic [59:0] kh_q;
  logic [31:0] kl_q;
  logic signed [61:0] det_q;
  logic signed [61:0] resp_q;
  logic [58:0] max_q;
  logic        raise_max;

  logic        ov_q;
  logic [60:0] resp_out_q;
  logic [9:0]  crow_q, ccol_q;
  logic [58:0] fmax_out_q;

  assign cur_col = frame_start_i ? '0 : col_cnt_q;
  assign cur_row = frame_start_i ? '0 : row_cnt_q;
  assign eff_w   = (cfg_i.image_width < hcr_pkg::WidthMin) ? hcr_pkg::WidthMin :
                   (cfg_i.image_width > hcr_pkg::WidthMax) ? hcr_pkg::WidthMax :
                   cfg_i.image_width;
  assign col_inc = 11'(cur_col) + 11'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) mem[clr_q] <= '0;
    else if (cmd_i.shift) mem[cur_col_q] <= {rd_q[47:0], pix_q};
    if (cmd_i.start) rd_q <= mem[cur_col];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      max_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + CW'(1);
      if (cmd_i.start) begin
        if (frame_start_i) max_q <= '0;
        if (col_inc >= eff_w) begin
          col_cnt_q <= '0;
          row_cnt_q <= (cur_row < hcr_pkg::RowLimit) ? cur_row + RW'(1) : cur_row;
        end else begin
          col_cnt_q <= col_inc[CW-1:0];
          row_cnt_q <= cur_row;
        end
      end
      if (cmd_i.load) begin
        ov_q <= 1'b1;
        if (raise_max) max_q <= resp_q[58:0];
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign colv[0] = rd_q[63:48];
  assign colv[1] = rd_q[47:32];
  assign colv[2] = rd_q[31:16];
  assign colv[3] = rd_q[15:0];
  assign colv[4] = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < hcr_pkg::Window; r++) begin
        for (int c = 0; c < hcr_pkg::Window; c++) win_q[r][c] <= '0;
      end
    end else if (cmd_i.shift) begin
      for (int r = 0; r < hcr_pkg::Window; r++) begin
        for (int c = 0; c < hcr_pkg::Window - 1; c++) win_q[r][c] <= win_q[r][c+1];
        win_q[r][hcr_pkg::Window-1] <= colv[r];
      end
    end
  end

  assign sel_pix = win_q[r_q][c_q];
  assign wt      = cfg_i.weight[hcr_pkg::weight_sel(r_q, c_q)];
  assign wx_full = sel_pix[7:0] * wt;
  assign wy_full = sel_pix[15:8] * wt;

  assign raise_max = !resp_q[61] && (resp_q != '0) && (resp_q > $signed({3'b000, max_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_col_q <= cur_col;
      cur_row_q <= cur_row;
      pix_q     <= {grad_y_i, grad_x_i};
    end
    if (cmd_i.shift) begin
      xx_q <= '0;
      yy_q <= '0;
      xy_q <= '0;
      r_q  <= '0;
      c_q  <= '0;
    end
    if (cmd_i.mul) begin
      wx_q <= wx_full[23:12];
      wy_q <= wy_full[23:12];
    end
    if (cmd_i.acc) begin
      xx_q <= xx_q + 29'(wx_q * wx_q);
      yy_q <= yy_q + 29'(wy_q * wy_q);
      xy_q <= xy_q + 29'(wx_q * wy_q);
      if (c_q == IW'(hcr_pkg::Window - 1)) begin
        c_q <= '0;
        r_q <= r_q + IW'(1);
      end else begin
        c_q <= c_q + IW'(1);
      end
    end
    if (cmd_i.fin1) begin
      tr_q   <= 30'(xx_q) + 30'(yy_q);
      xxyy_q <= xx_q * yy_q;
    end
    if (cmd_i.fin2) begin
      t2_q   <= tr_q * tr_q;
      xyxy_q <= xy_q * xy_q;
    end
    if (cmd_i.fin3) begin
      kh_q  <= t2_q[59:16] * cfg_i.k_coeff;
      kl_q  <= t2_q[15:0] * cfg_i.k_coeff;
      det_q <= $signed({4'b0000, xxyy_q}) - $signed({4'b0000, xyxy_q});
    end
    if (cmd_i.fin4) begin
      resp_q <= det_q - $signed({2'b00, kh_q + 60'(kl_q[31:16])});
    end
    if (cmd_i.load) begin
      resp_out_q <= resp_q[60:0];
      crow_q     <= cur_row_q - RW'(2);
      ccol_q     <= 10'(cur_col_q) - 10'd2;
      // The maximum shown with a result is frozen with it, so a frame start on
      // the next pixel cannot change a result that is still waiting.
      fmax_out_q <= raise_max ? resp_q[58:0] : max_q;
    end
  end

  assign status_o.clr_last    = (clr_q == '1);
  assign status_o.want_result = (cur_row_q >= RW'(4)) && (cur_col_q >= CW'(4));
  assign status_o.idx_last    = (r_q == IW'(hcr_pkg::Window - 1)) &&
                                (c_q == IW'(hcr_pkg::Window - 1));
  assign status_o.out_free    = !ov_q || out_ready_i;

  assign out_valid_o  = ov_q;
  assign response_o   = resp_out_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;
  assign frame_max_o  = fmax_out_q;

endmodule

@@ sv/harris_corner_response_unit.sv @@
// ----------------------------------------------------------------------------
// harris_corner_response_unit
// Harris corner response over a raster stream of gradient pairs.
// ----------------------------------------------------------------------------
// The input channel carries one pixel per transaction: unsigned x and y
// gradients and a frame_start flag on the first pixel of a frame, which
// clears the row and column counters and the running frame maximum.
// The output channel carries one transaction for every pixel whose row and
// column are both at least four: the response at the window centre two rows
// and two columns back, the centre's position and the frame maximum.
// Settings are written through the APB port while the unit is idle.
//
// A pixel that yields no result is accepted with a line store read, then the
// window is updated. For a pixel with a result, the 25 window taps are then
// weighted and accumulated one tap at a time, each in a multiply state and
// an accumulate state; the finish states StFin1 to StFin4 compute det and
// k*trace^2, and StLoad loads the output register.
// The output register lets the unit take the next pixel while a result waits;
// if the receiver stalls, the next result holds the unit until it is taken.
// After reset the unit sweeps the 1024-word line store to zero, one word per
// cycle, and takes no pixel until the sweep is done.
module harris_corner_response_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hcr_in_if.sink                     in_if,
  hcr_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hcr_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  hcr_pkg::cfg_t    cfg_q;
  hcr_pkg::cmd_t    cmd;
  hcr_pkg::status_t status;
  hcr_pkg::reg_idx_e reg_idx;
  logic             cfg_wr;

  assign reg_idx = hcr_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register file: plain writes, reset values as the default kernel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= 11'd640;
      cfg_q.k_coeff     <= 16'd2621;
      cfg_q.weight[0]   <= 16'd10624;
      cfg_q.weight[1]   <= 16'd6442;
      cfg_q.weight[2]   <= 16'd1435;
      cfg_q.weight[3]   <= 16'd3906;
      cfg_q.weight[4]   <= 16'd872;
      cfg_q.weight[5]   <= 16'd197;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hcr_pkg::RegImageWidth: cfg_q.image_width <= pwdata[10:0];
        hcr_pkg::RegKCoeff:     cfg_q.k_coeff     <= pwdata[15:0];
        hcr_pkg::RegWCenter:    cfg_q.weight[0]   <= pwdata[15:0];
        hcr_pkg::RegWAxisNear:  cfg_q.weight[1]   <= pwdata[15:0];
        hcr_pkg::RegWAxisFar:   cfg_q.weight[2]   <= pwdata[15:0];
        hcr_pkg::RegWDiagNear:  cfg_q.weight[3]   <= pwdata[15:0];
        hcr_pkg::RegWKnight:    cfg_q.weight[4]   <= pwdata[15:0];
        hcr_pkg::RegWCorner:    cfg_q.weight[5]   <= pwdata[15:0];
        default:                cfg_q             <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hcr_pkg::RegImageWidth: prdata = {21'd0, cfg_q.image_width};
      hcr_pkg::RegKCoeff:     prdata = {16'd0, cfg_q.k_coeff};
      hcr_pkg::RegWCenter:    prdata = {16'd0, cfg_q.weight[0]};
      hcr_pkg::RegWAxisNear:  prdata = {16'd0, cfg_q.weight[1]};
      hcr_pkg::RegWAxisFar:   prdata = {16'd0, cfg_q.weight[2]};
      hcr_pkg::RegWDiagNear:  prdata = {16'd0, cfg_q.weight[3]};
      hcr_pkg::RegWKnight:    prdata = {16'd0, cfg_q.weight[4]};
      hcr_pkg::RegWCorner:    prdata = {16'd0, cfg_q.weight[5]};
      default:                prdata = '0;
    endcase
  end

  hcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .grad_x_i      (in_if.grad_x),
    .grad_y_i      (in_if.grad_y),
    .frame_start_i (in_if.frame_start),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .response_o    (out_if.response),
    .center_row_o  (out_if.center_row),
    .center_col_o  (out_if.center_col),
    .frame_max_o   (out_if.frame_max)
  );

  // One pixel at a time: the input is closed in the cycle after a transaction.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted twice in a row");

  // The frame maximum never trails a positive response it has seen.
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.response[60]) |->
      ({2'b00, out_if.frame_max} >= out_if.response))
    else $error("frame maximum below shown response");

  // A result always names an interior centre.
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.center_row >= 10'd2 && out_if.center_col >= 10'd2))
    else $error("result outside the image interior");

endmodule

@@ test/tb_harris_corner_response_unit.sv @@
// ----------------------------------------------------------------------------
// tb_harris_corner_response_unit
// Self-checking testbench of the Harris corner response unit.
// ----------------------------------------------------------------------------
// Gradient pixels are queued by the stimulus process and offered by a clocked
// driver. Every accepted pixel runs through a behavioral predictor of the
// line stores, the 5x5 window and the fixed-point response arithmetic. Each
// output transaction is compared field by field with the oldest predicted
// response. Settings are changed over APB only while the unit is idle.
// ----------------------------------------------------------------------------
module tb_harris_corner_response_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 100;
  localparam int unsigned StallLimit   = 6000;
  localparam int unsigned HoldCycles   = 400;

  typedef struct {
    logic [7:0] gx;
    logic [7:0] gy;
    logic       fs;
  } pixel_t;

  typedef struct {
    logic [60:0] response;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [58:0] fmax;
  } corner_t;

  logic clk_i;
  logic rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [hcr_pkg::AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hcr_in_if  in_if ();
  hcr_out_if out_if ();

  harris_corner_response_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pixels waiting to be offered and corner responses waiting to arrive.
  pixel_t  pixel_q[$];
  corner_t corner_q[$];

  // The testbench's own copy of the settings, updated as each write lands.
  logic [10:0] width_set;
  logic [15:0] k_set;
  logic [15:0] wt_set[hcr_pkg::NumWeight];

  // Predictor state.
  logic [15:0] line_mem[4*hcr_pkg::MaxWidth];
  logic [15:0] win[hcr_pkg::Window][hcr_pkg::Window];
  logic [9:0]  col_cnt;
  logic [9:0]  row_cnt;
  logic [58:0] max_seen;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  logic        hold_req;
  logic        hold_seen;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Everything the unit sees is at a known level from time zero.
  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.grad_x = '0;
    in_if.grad_y = '0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    hold_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    quiet_cycles = 0;
    mismatches = 0;
    width_set = 11'd640;
    k_set = 16'd2621;
    wt_set[0] = 16'd10624;
    wt_set[1] = 16'd6442;
    wt_set[2] = 16'd1435;
    wt_set[3] = 16'd3906;
    wt_set[4] = 16'd872;
    wt_set[5] = 16'd197;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    col_cnt = '0;
    row_cnt = '0;
    max_seen = '0;
  end

  // Weight register for a window tap. The squared distance from the centre
  // identifies the six symmetric classes uniquely.
  function automatic logic [15:0] tap_weight(input int r, input int c);
    int d;
    d = (r - 2) * (r - 2) + (c - 2) * (c - 2);
    case (d)
      0: return wt_set[0];
      1: return wt_set[1];
      4: return wt_set[2];
      2: return wt_set[3];
      5: return wt_set[4];
      default: return wt_set[5];
    endcase
  endfunction

  // Advances the predictor by one accepted pixel and queues the response it
  // produces, if any.
  task automatic track_pixel(input pixel_t px);
    int unsigned w;
    int unsigned ci;
    logic [15:0] colv[hcr_pkg::Window];
    longint unsigned xx, yy, xy, wx, wy, tr, t2, ktr, wt;
    longint signed resp;
    corner_t res;
    if (px.fs) begin
      col_cnt = '0;
      row_cnt = '0;
      max_seen = '0;
    end
    w = width_set;
    if (w < 5) w = 5;
    if (w > hcr_pkg::MaxWidth) w = hcr_pkg::MaxWidth;
    ci = col_cnt;
    colv[0] = line_mem[3*hcr_pkg::MaxWidth + ci];
    colv[1] = line_mem[2*hcr_pkg::MaxWidth + ci];
    colv[2] = line_mem[hcr_pkg::MaxWidth + ci];
    colv[3] = line_mem[ci];
    colv[4] = {px.gy, px.gx};
    line_mem[3*hcr_pkg::MaxWidth + ci] = colv[1];
    line_mem[2*hcr_pkg::MaxWidth + ci] = colv[2];
    line_mem[hcr_pkg::MaxWidth + ci] = colv[3];
    line_mem[ci] = colv[4];
    for (int r = 0; r < hcr_pkg::Window; r++) begin
      for (int c = 0; c < hcr_pkg::Window - 1; c++) win[r][c] = win[r][c+1];
      win[r][hcr_pkg::Window-1] = colv[r];
    end
    if (row_cnt >= 4 && col_cnt >= 4) begin
      xx = 0;
      yy = 0;
      xy = 0;
      for (int r = 0; r < hcr_pkg::Window; r++) begin
        for (int c = 0; c < hcr_pkg::Window; c++) begin
          wt = tap_weight(r, c);
          wx = (longint'(win[r][c][7:0]) * wt) >> 12;
          wy = (longint'(win[r][c][15:8]) * wt) >> 12;
          xx += wx * wx;
          yy += wy * wy;
          xy += wx * wy;
        end
      end
      tr = xx + yy;
      t2 = tr * tr;
      // k * trace^2 in Q.16, split so that the product never overflows.
      ktr = (t2 >> 16) * k_set + (((t2 & 64'hFFFF) * k_set) >> 16);
      resp = longint'(xx * yy) - longint'(xy * xy) - longint'(ktr);
      if (resp > 0 && longint'(resp) > longint'({5'b0, max_seen})) max_seen = resp[58:0];
      res.response = resp[60:0];
      res.row = row_cnt - 10'd2;
      res.col = col_cnt - 10'd2;
      res.fmax = max_seen;
      corner_q = {corner_q, res};
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = '0;
      if (row_cnt < hcr_pkg::RowLimit) row_cnt = row_cnt + 10'd1;
    end else begin
      col_cnt = col_cnt + 10'd1;
    end
  endtask

  // Pixel driver: a pixel stays on the bus until it is taken, and a new one
  // is offered only when the sender is not idling this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        track_pixel(pixel_q[0]);
        pixel_q.pop_front();
      end
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.grad_x <= pixel_q[0].gx;
          in_if.grad_y <= pixel_q[0].gy;
          in_if.frame_start <= pixel_q[0].fs;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so that the
  // output register fills and the unit has to stall its input.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    corner_t exp_c;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (corner_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %0d at row %0d col %0d",
                                       $signed(out_if.response), out_if.center_row,
                                       out_if.center_col);
      end else begin
        exp_c = corner_q.pop_front();
        if (out_if.response !== exp_c.response || out_if.center_row !== exp_c.row ||
            out_if.center_col !== exp_c.col || out_if.frame_max !== exp_c.fmax) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected resp %0d row %0d col %0d max %0d",
                     $signed(exp_c.response), exp_c.row, exp_c.col, exp_c.fmax);
            $display("          actual   resp %0d row %0d col %0d max %0d",
                     $signed(out_if.response), out_if.center_row, out_if.center_col,
                     out_if.frame_max);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction completes on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One APB write: setup cycle, then access cycle. The local copy changes
  // at the edge where the unit takes the write.
  task automatic apb_write(input hcr_pkg::reg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hcr_pkg::AddrW'(idx) << 2;
    pwdata <= {16'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hcr_pkg::RegImageWidth: width_set = val[10:0];
      hcr_pkg::RegKCoeff:     k_set = val;
      default:                wt_set[int'(idx) - int'(hcr_pkg::RegWCenter)] = val;
    endcase
  endtask

  task automatic apply_settings(input logic [10:0] w, input logic [15:0] k,
                                input logic [15:0] wc, input logic [15:0] wan,
                                input logic [15:0] waf, input logic [15:0] wdn,
                                input logic [15:0] wkn, input logic [15:0] wco);
    apb_write(hcr_pkg::RegImageWidth, {5'b0, w});
    apb_write(hcr_pkg::RegKCoeff, k);
    apb_write(hcr_pkg::RegWCenter, wc);
    apb_write(hcr_pkg::RegWAxisNear, wan);
    apb_write(hcr_pkg::RegWAxisFar, waf);
    apb_write(hcr_pkg::RegWDiagNear, wdn);
    apb_write(hcr_pkg::RegWKnight, wkn);
    apb_write(hcr_pkg::RegWCorner, wco);
  endtask

  // Waits until every queued pixel is taken and every response has arrived,
  // then lets a pixel that yields no result finish inside the unit.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_if.valid || corner_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_grad();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [7:0] gx, input logic [7:0] gy, input logic fs);
    pixel_t px;
    px.gx = gx;
    px.gy = gy;
    px.fs = fs;
    pixel_q = {pixel_q, px};
  endtask

  // Random frames: mostly complete frames with random content, some cut
  // short, with an occasional stray frame start in the middle.
  task automatic queue_frames(input int unsigned n_items);
    int unsigned w, rows, cnt, len;
    cnt = 0;
    w = width_set;
    if (w < 5) w = 5;
    if (w > hcr_pkg::MaxWidth) w = hcr_pkg::MaxWidth;
    while (cnt < n_items) begin
      rows = $urandom_range(5, 7);
      len = rows * w;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
      for (int unsigned i = 0; i < len; i++) begin
        push_pixel(rand_grad(), rand_grad(), (i == 0) || ($urandom_range(0, 199) == 0));
      end
      cnt += len;
    end
  endtask

  task automatic random_settings();
    apply_settings(11'($urandom_range(5, 10)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000)),
                   16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings and no frame start: counting begins from reset values.
    for (int i = 0; i < 12; i++) push_pixel(rand_grad(), rand_grad(), 1'b0);
    wait_idle();

    // The width shrinks mid-row, so the column wraps at once; results then
    // appear once four rows have been stored, still without a frame start.
    apb_write(hcr_pkg::RegImageWidth, 16'd5);
    for (int i = 0; i < 25; i++) push_pixel(8'd255, 8'd0, 1'b0);
    wait_idle();

    // Directed frame at the extremes: full weights, k zero, then k at its top.
    apply_settings(11'd5, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 25; i++) begin
      push_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd255 : 8'd0, i == 0);
    end
    wait_idle();
    apb_write(hcr_pkg::RegKCoeff, 16'hFFFF);
    for (int i = 0; i < 25; i++) push_pixel(8'd255, 8'd255, i == 0);
    wait_idle();

    // Width below the minimum acts as the minimum; zero weights give zero.
    apply_settings(11'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 25; i++) push_pixel(rand_grad(), rand_grad(), i == 0);
    wait_idle();

    // Width above the maximum acts as the maximum; one partial row only.
    apply_settings(11'h7FF, 16'd2621, 16'd10624, 16'd6442, 16'd1435,
                   16'd3906, 16'd872, 16'd197);
    for (int i = 0; i < 40; i++) push_pixel(rand_grad(), rand_grad(), i == 0);
    wait_idle();

    // Random phases, one per idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      random_settings();
      queue_frames(100);
      if (ph == 2) begin
        @(posedge clk_i);
        hold_req <= ~hold_req;
      end
      wait_idle();
    end

    if (mismatches == 0 && corner_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hcr_pkg.sv
sv/hcr_if.sv
sv/hcr_ctrl.sv
sv/hcr_dpath.sv
sv/harris_corner_response_unit.sv
test/tb_harris_corner_response_unit.sv
